// File: src/kti_pkg.sv
// ----------------------------------------------------------------------------
// Keyframe track interpolator package
// Shared widths, codes, state machine states and the control structures that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package kti_pkg;

	localparam int MAX_KEYS_DEF  = 256;
	localparam int FRAC_BITS_DEF = 16;

	localparam int ROW_W   = 16;
	localparam int VAL_W   = 32;
	localparam int QROW_W  = 32;
	localparam int DELTA_W = 15;
	localparam int KIND_W  = 3;
	localparam int CMD_W   = 2;
	localparam int STS_W   = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_code_t;

	typedef enum logic [STS_W-1:0] {
		STS_DONE    = 2'd0,
		STS_STORED  = 2'd1,
		STS_DROPPED = 2'd2
	} sts_code_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_STEP   = 3'd0,
		KIND_LINEAR = 3'd1,
		KIND_SMOOTH = 3'd2,
		KIND_RAMP   = 3'd3
	} kind_code_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_PROBE,
		S_CMP,
		S_PICK,
		S_F0,
		S_F1,
		S_CHK,
		S_DIV,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_SUM,
		S_DONE
	} state_t;

	typedef struct packed {
		logic latch;
		logic exec;
		logic probe;
		logic step;
		logic pick;
		logic fetch0;
		logic fetch1;
		logic chk;
		logic div;
		logic mul1;
		logic mul2;
		logic mul3;
		logic sum;
		logic res_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_query;
		logic count_zero;
		logic srch_done;
		logic edge_hit;
		logic need_math;
		logic div_last;
	} ctl_sts_t;

endpackage

// File: src/kti_channels.sv
// ----------------------------------------------------------------------------
// Keyframe track interpolator channels
// Valid/ready interfaces for the command word and the result word.
// ----------------------------------------------------------------------------
interface kti_req_if;
	logic                 valid;
	logic                 ready;
	logic [1:0]           command;
	logic [14:0]          delta_row;
	logic signed [31:0]   key_value;
	logic [2:0]           key_kind;
	logic [31:0]          query_row;

	modport source (output valid, command, delta_row, key_value, key_kind, query_row,
		input ready);
	modport sink (input valid, command, delta_row, key_value, key_kind, query_row,
		output ready);
endinterface

interface kti_rsp_if;
	logic                 valid;
	logic                 ready;
	logic [1:0]           status;
	logic signed [31:0]   track_value;

	modport source (output valid, status, track_value, input ready);
	modport sink (input valid, status, track_value, output ready);
endinterface

// File: src/kti_ctrl.sv
// ----------------------------------------------------------------------------
// Keyframe track interpolator controller
// Sequences each word through execution and, as a query needs, the binary
// search, key fetch, serial division, multiplies; owns the result valid flag.
// ----------------------------------------------------------------------------
module kti_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  kti_pkg::ctl_sts_t sts,
	output kti_pkg::ctl_cmd_t cmd
);
	import kti_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = (sts.is_query && !sts.count_zero) ? S_PROBE : S_DONE;
			end
			S_PROBE: begin
				cmd.probe = 1'b1;
				state_d   = S_CMP;
			end
			S_CMP: begin
				cmd.step = 1'b1;
				state_d  = sts.srch_done ? S_PICK : S_PROBE;
			end
			S_PICK: begin
				cmd.pick = 1'b1;
				state_d  = S_F0;
			end
			S_F0: begin
				cmd.fetch0 = 1'b1;
				state_d    = sts.edge_hit ? S_DONE : S_F1;
			end
			S_F1: begin
				cmd.fetch1 = 1'b1;
				state_d    = S_CHK;
			end
			S_CHK: begin
				cmd.chk = 1'b1;
				state_d = sts.need_math ? S_DIV : S_DONE;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				state_d = sts.div_last ? S_MUL1 : S_DIV;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_MUL3;
			end
			S_MUL3: begin
				cmd.mul3 = 1'b1;
				state_d  = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_EXEC)
		else $error("accepted word did not enter execution");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while still held");

	a_div_complete: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL1 |-> $past(state_q) == S_DIV && $past(sts.div_last))
		else $error("multiply started before the division finished");

endmodule

// File: src/kti_dp.sv
// ----------------------------------------------------------------------------
// Keyframe track interpolator datapath
// Key table memories, running row, search bounds, serial divider for the
// blend factor, the shaping multiplies and the result register.
// ----------------------------------------------------------------------------
module kti_dp #(
	parameter int MAX_KEYS  = kti_pkg::MAX_KEYS_DEF,
	parameter int FRAC_BITS = kti_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  kti_pkg::ctl_cmd_t                cmd,
	output kti_pkg::ctl_sts_t                sts,
	input  logic [kti_pkg::CMD_W-1:0]        command,
	input  logic [kti_pkg::DELTA_W-1:0]      delta_row,
	input  logic signed [kti_pkg::VAL_W-1:0] key_value,
	input  logic [kti_pkg::KIND_W-1:0]       key_kind,
	input  logic [kti_pkg::QROW_W-1:0]       query_row,
	output logic [kti_pkg::STS_W-1:0]        status,
	output logic signed [kti_pkg::VAL_W-1:0] track_value
);
	import kti_pkg::*;

	localparam int AW     = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CNT_W  = $clog2(MAX_KEYS + 1);
	localparam int IROW_W = QROW_W - FRAC_BITS;
	localparam int CMP_W  = (IROW_W > ROW_W) ? IROW_W : ROW_W;
	localparam int REM_W  = ROW_W + 1;
	localparam int DCNT_W = $clog2(FRAC_BITS);
	localparam int PROD_W = VAL_W + FRAC_BITS + 2;
	localparam logic [FRAC_BITS+1:0] THREE = (FRAC_BITS + 2)'(3) << FRAC_BITS;

	logic [ROW_W-1:0]         rows_mem [MAX_KEYS];
	logic signed [VAL_W-1:0]  vals_mem [MAX_KEYS];
	logic [KIND_W-1:0]        kinds_mem [MAX_KEYS];

	cmd_code_t                cmd_q;
	logic [DELTA_W-1:0]       delta_q;
	logic signed [VAL_W-1:0]  kval_q;
	logic [KIND_W-1:0]        kkind_q;
	logic [QROW_W-1:0]        qrow_q;

	logic [CNT_W-1:0]         count_q;
	logic [ROW_W-1:0]         run_q;
	logic                     drop_q;

	logic [AW-1:0]            rd_addr;
	logic [ROW_W-1:0]         rd_row_q;
	logic signed [VAL_W-1:0]  rd_val_q;
	logic [KIND_W-1:0]        rd_kind_q;

	logic [CNT_W-1:0]         lo_q;
	logic [CNT_W-1:0]         hi_q;
	logic [AW-1:0]            idx_q;
	logic                     edge_q;

	logic [ROW_W-1:0]         row0_q;
	logic signed [VAL_W-1:0]  v0_q;
	logic signed [VAL_W-1:0]  v1_q;
	logic [KIND_W-1:0]        kind0_q;
	logic [ROW_W-1:0]         span_q;

	logic [REM_W-1:0]         rem_q;
	logic [FRAC_BITS-1:0]     numlo_q;
	logic                     ovf_q;
	logic [DCNT_W-1:0]        dcnt_q;
	logic [FRAC_BITS-1:0]     t_q;
	logic [FRAC_BITS-1:0]     t2_q;
	logic [FRAC_BITS-1:0]     s_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [VAL_W-1:0]  val_q;

	logic [STS_W-1:0]         res_status_q;
	logic signed [VAL_W-1:0]  res_value_q;

	logic                     full;
	logic                     load_ok;
	logic [ROW_W:0]           rsum;
	logic [ROW_W-1:0]         rnew;

	logic [CNT_W:0]           sum_lh;
	logic [CNT_W-1:0]         mi;
	logic [CMP_W-1:0]         irow_ext;
	logic [CMP_W-1:0]         krow_ext;
	logic                     lt;
	logic                     eq;
	logic [CNT_W-1:0]         lo_n;
	logic [CNT_W-1:0]         hi_n;
	logic                     pre_first;
	logic                     after;
	logic [CNT_W-1:0]         idxv;
	logic [CNT_W-1:0]         sel;

	logic                     interp_kind;
	logic signed [VAL_W-1:0]  direct_val;
	logic [QROW_W-1:0]        num;
	logic [CMP_W-1:0]         hi_ext;
	logic [REM_W-1:0]         trial;
	logic                     ge;

	logic [2*FRAC_BITS-1:0]   tsq;
	logic [FRAC_BITS+1:0]     fac;
	logic [2*FRAC_BITS+1:0]   smq;
	logic signed [VAL_W:0]    diff;
	logic signed [PROD_W-1:0] shifted;

	assign full    = (count_q == CNT_W'(MAX_KEYS));
	assign load_ok = (cmd_q == CMD_LOAD) && !full;
	assign rsum    = {1'b0, run_q} + REM_W'(delta_q);
	assign rnew    = rsum[ROW_W] ? '1 : rsum[ROW_W-1:0];

	assign sum_lh    = {1'b0, lo_q} + {1'b0, hi_q};
	assign mi        = sum_lh[CNT_W:1];
	assign irow_ext  = CMP_W'(qrow_q[QROW_W-1:FRAC_BITS]);
	assign krow_ext  = CMP_W'(rd_row_q);
	assign lt        = krow_ext < irow_ext;
	assign eq        = krow_ext == irow_ext;
	assign lo_n      = lt ? (mi + 1'b1) : lo_q;
	assign hi_n      = (lt || eq) ? hi_q : mi;
	assign pre_first = !eq && (lo_n == '0);
	assign idxv      = eq ? mi : (lo_n - 1'b1);
	assign after     = !pre_first && (({1'b0, idxv} + 1'b1) >= {1'b0, count_q});
	assign sel       = pre_first ? '0 : (after ? (count_q - 1'b1) : idxv);

	assign interp_kind = (kind0_q == KIND_LINEAR) || (kind0_q == KIND_SMOOTH) ||
		(kind0_q == KIND_RAMP);
	assign direct_val  = ((kind0_q == KIND_STEP) || (interp_kind && span_q == '0)) ?
		v0_q : '0;
	assign num    = qrow_q - (QROW_W'(row0_q) << FRAC_BITS);
	assign hi_ext = CMP_W'(num[QROW_W-1:FRAC_BITS]);
	assign trial  = {rem_q[ROW_W-1:0], numlo_q[FRAC_BITS-1]};
	assign ge     = trial >= {1'b0, span_q};

	assign tsq     = t_q * t_q;
	assign fac     = THREE - {1'b0, t_q, 1'b0};
	assign smq     = t2_q * fac;
	assign diff    = {v1_q[VAL_W-1], v1_q} - {v0_q[VAL_W-1], v0_q};
	assign shifted = prod_q >>> FRAC_BITS;

	always_comb begin
		rd_addr = idx_q;
		if (cmd.probe) begin
			rd_addr = mi[AW-1:0];
		end else if (cmd.fetch0) begin
			rd_addr = idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && load_ok) begin
			rows_mem[count_q[AW-1:0]]  <= rnew;
			vals_mem[count_q[AW-1:0]]  <= kval_q;
			kinds_mem[count_q[AW-1:0]] <= kkind_q;
		end
		rd_row_q  <= rows_mem[rd_addr];
		rd_val_q  <= vals_mem[rd_addr];
		rd_kind_q <= kinds_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			run_q   <= '0;
		end else if (cmd.exec) begin
			if (cmd_q == CMD_CLEAR) begin
				count_q <= '0;
				run_q   <= '0;
			end else if (load_ok) begin
				count_q <= count_q + 1'b1;
				run_q   <= rnew;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cmd_q   <= cmd_code_t'(command);
			delta_q <= delta_row;
			kval_q  <= key_value;
			kkind_q <= key_kind;
			qrow_q  <= query_row;
		end
		if (cmd.exec) begin
			val_q  <= '0;
			drop_q <= (cmd_q == CMD_LOAD) && full;
			lo_q   <= '0;
			hi_q   <= count_q;
		end
		if (cmd.step) begin
			lo_q   <= lo_n;
			hi_q   <= hi_n;
			idx_q  <= sel[AW-1:0];
			edge_q <= pre_first || after;
		end
		if (cmd.fetch0) begin
			row0_q  <= rd_row_q;
			v0_q    <= rd_val_q;
			kind0_q <= rd_kind_q;
			val_q   <= rd_val_q;
		end
		if (cmd.fetch1) begin
			v1_q   <= rd_val_q;
			span_q <= rd_row_q - row0_q;
		end
		if (cmd.chk) begin
			val_q   <= direct_val;
			rem_q   <= REM_W'(hi_ext);
			numlo_q <= num[FRAC_BITS-1:0];
			ovf_q   <= hi_ext >= CMP_W'(span_q);
			dcnt_q  <= '0;
		end
		if (cmd.div) begin
			rem_q   <= ge ? (trial - {1'b0, span_q}) : trial;
			t_q     <= {t_q[FRAC_BITS-2:0], ovf_q | ge};
			numlo_q <= numlo_q << 1;
			dcnt_q  <= dcnt_q + 1'b1;
		end
		if (cmd.mul1) begin
			t2_q <= tsq[2*FRAC_BITS-1:FRAC_BITS];
		end
		if (cmd.mul2) begin
			case (kind0_q)
				KIND_SMOOTH: s_q <= smq[2*FRAC_BITS-1:FRAC_BITS];
				KIND_RAMP:   s_q <= t2_q;
				default:     s_q <= t_q;
			endcase
		end
		if (cmd.mul3) begin
			prod_q <= diff * $signed({1'b0, s_q});
		end
		if (cmd.sum) begin
			val_q <= v0_q + shifted[VAL_W-1:0];
		end
		if (cmd.res_load) begin
			res_value_q <= val_q;
			if (cmd_q == CMD_LOAD) begin
				res_status_q <= drop_q ? STS_DROPPED : STS_STORED;
			end else begin
				res_status_q <= STS_DONE;
			end
		end
	end

	assign sts.is_query   = (cmd_q == CMD_QUERY);
	assign sts.count_zero = (count_q == '0);
	assign sts.srch_done  = eq || (lo_n >= hi_n);
	assign sts.edge_hit   = edge_q;
	assign sts.need_math  = interp_kind && (span_q != '0);
	assign sts.div_last   = (dcnt_q == DCNT_W'(FRAC_BITS - 1));

	assign status      = res_status_q;
	assign track_value = res_value_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_KEYS))
		else $error("key count beyond table depth");

	a_probe_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.probe |-> lo_q < hi_q)
		else $error("search probe with an empty interval");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && cmd_q == CMD_LOAD && full |=> drop_q && $stable(count_q))
		else $error("load into a full table was not dropped");

endmodule

// File: src/keyframe_track_interpolator.sv
// ----------------------------------------------------------------------------
// Keyframe track interpolator
// One keyframe track: clear, append keys with a saturating running row, and
// answer interpolated values at fractional rows.
// ----------------------------------------------------------------------------
// Port  Dir  Word contents
// req   in   command, delta_row, key_value, key_kind, query_row
// rsp   out  status, track_value
//
// Clear and load words go from accept through execution to the result load.
// A query also runs the binary search (ceil(log2(keys))+1 probes at most,
// each a memory read and compare), the key fetch, the bit-serial divider
// and the multiply/add steps, but skips the rest once its value is known.
// A new word is accepted only once the previous result sits in the output
// register; a stalled output holds the result. Reset clears count and row.
// ----------------------------------------------------------------------------
module keyframe_track_interpolator #(
	parameter int MAX_KEYS  = kti_pkg::MAX_KEYS_DEF,
	parameter int FRAC_BITS = kti_pkg::FRAC_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	kti_req_if.sink   req,
	kti_rsp_if.source rsp
);
	import kti_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	kti_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	kti_dp #(
		.MAX_KEYS  (MAX_KEYS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.command     (req.command),
		.delta_row   (req.delta_row),
		.key_value   (req.key_value),
		.key_kind    (req.key_kind),
		.query_row   (req.query_row),
		.status      (rsp.status),
		.track_value (rsp.track_value)
	);

endmodule
